// ===== design/bsr_pkg.sv =====
`timescale 1ns / 1ps
package bsr_pkg;

    localparam int MAX_BLOCK_DEF   = 512;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SIGMA_SQ        = 9;

    typedef enum logic
    {
        OP_LOAD,
        OP_READ
    } op_t;

    typedef enum logic [3:0]
    {
        ST_LOAD,
        ST_PRE_MUL,
        ST_PRE_SUB,
        ST_PRE_LIM,
        ST_SCAN,
        ST_DIV,
        ST_DIV_FIX,
        ST_READY,
        ST_FETCH
    } state_t;

    typedef struct packed
    {
        logic vld;
        op_t  op;
        logic last;
    } ctl_t;

endpackage

// ===== design/bsr_ram.sv =====
`timescale 1ns / 1ps
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bsr_front.sv =====
`timescale 1ns / 1ps
module bsr_front import bsr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   kind,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   is_last,
    output ctl_t                   head,
    output logic [SAMPLE_BITS-1:0] head_sample,
    input  logic                   pop
);

    op_t                    op_reg   [2];
    logic                   last_reg [2];
    logic [SAMPLE_BITS-1:0] smp_reg  [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push;

    assign item_stall  = (cnt_reg == 2'd2);
    assign push        = item_valid && !item_stall;
    assign head.vld    = (cnt_reg != 2'd0);
    assign head.op     = op_reg[rd_ptr_reg];
    assign head.last   = last_reg[rd_ptr_reg];
    assign head_sample = smp_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]   <= kind ? OP_READ : OP_LOAD;
            last_reg[wr_ptr_reg] <= is_last;
            smp_reg[wr_ptr_reg]  <= sample;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");

endmodule

// ===== design/bsr_back.sv =====
`timescale 1ns / 1ps
module bsr_back import bsr_pkg::*; #(
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_t                   head,
    input  logic [SAMPLE_BITS-1:0] head_sample,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [SAMPLE_BITS-1:0] cleaned_sample,
    output logic                   was_spike,
    output logic                   last_out
);

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int AW  = $clog2(MAX_BLOCK);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS + CW;
    localparam int VW  = 2 * SW;
    localparam int DW  = SAMPLE_BITS + CW + 2;
    localparam int LW  = 2 * DW + CW;
    localparam int KW  = CW + 4;
    localparam int DCW = $clog2(SW);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic [QW-1:0]            sq_reg, sq_next;
    logic signed [SW-1:0]     good_sum_reg, good_sum_next;
    logic [CW-1:0]            good_cnt_reg, good_cnt_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic [VW-1:0]            nq_reg, nq_next;
    logic [VW-1:0]            ss_reg, ss_next;
    logic [VW-1:0]            var_reg, var_next;
    logic [LW-1:0]            limit_reg, limit_next;
    logic [SW-1:0]            quo_reg, quo_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic [DCW-1:0]           div_cnt_reg, div_cnt_next;
    logic [SAMPLE_BITS-1:0]   mean_reg, mean_next;

    logic [3:0]               v_reg, v_next;
    logic [AW-1:0]            idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [SAMPLE_BITS-1:0]   x2_reg, x3_reg, x4_reg;
    logic signed [DW-1:0]     d_reg, d_next;
    logic [2*DW-1:0]          d2_reg, d2_next;
    logic [LW-1:0]            lhs_reg, lhs_next;

    logic                     res_vld_reg, res_vld_next;
    logic [SAMPLE_BITS-1:0]   res_smp_reg, res_smp_next;
    logic                     res_spk_reg, res_spk_next;
    logic                     res_last_reg, res_last_next;

    logic                     smp_we;
    logic [AW-1:0]            smp_waddr;
    logic [AW-1:0]            smp_raddr;
    logic [SAMPLE_BITS-1:0]   smp_rdata;
    logic                     spk_we;
    logic                     spk_wdata;
    logic                     spk_rdata;

    logic                     out_free;
    logic                     ready_ph;
    logic [CW-1:0]            b_cnt;
    logic signed [SW-1:0]     b_sum;
    logic [QW-1:0]            b_sq;
    logic                     room;
    logic signed [2*SAMPLE_BITS-1:0] xx;
    logic                     issue;
    logic                     spike;
    logic [DW-1:0]            dm;
    logic signed [VW-1:0]     ssq;
    logic [KW-1:0]            kmul;
    logic [CW:0]              trial;
    logic                     ge;
    logic [SW-1:0]            qneg;
    logic                     fetch_last;

    bsr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_BLOCK)) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (head_sample),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    bsr_ram #(.WIDTH(1), .DEPTH(MAX_BLOCK)) u_spk_ram (
        .clk   (clk),
        .we    (spk_we),
        .waddr (idx4_reg),
        .wdata (spk_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (spk_rdata)
    );

    assign result_valid   = res_vld_reg;
    assign cleaned_sample = res_smp_reg;
    assign was_spike      = res_spk_reg;
    assign last_out       = res_last_reg;

    assign out_free  = !res_vld_reg || !result_stall;
    assign ready_ph  = (state_reg == ST_READY);
    assign b_cnt     = ready_ph ? '0 : cnt_reg;
    assign b_sum     = ready_ph ? '0 : sum_reg;
    assign b_sq      = ready_ph ? '0 : sq_reg;
    assign room      = (b_cnt < CW'(MAX_BLOCK));
    assign xx        = $signed(head_sample) * $signed(head_sample);
    assign issue     = (state_reg == ST_SCAN) && (scan_reg < cnt_reg);
    assign smp_raddr = (state_reg == ST_SCAN) ? scan_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign smp_waddr = b_cnt[AW-1:0];

    assign pop = head.vld && ((state_reg == ST_LOAD) || ready_ph)
                 && ((head.op == OP_LOAD) || out_free);
    assign smp_we = pop && (head.op == OP_LOAD) && room;

    assign spike     = (cnt_reg >= CW'(2)) && (lhs_reg > limit_reg);
    assign spk_we    = v_reg[3];
    assign spk_wdata = spike;

    assign dm      = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
    assign ssq     = VW'(sum_reg) * VW'(sum_reg);
    assign kmul    = KW'(SIGMA_SQ) * KW'(cnt_reg);
    assign trial   = {rem_reg, quo_reg[SW-1]};
    assign ge      = (trial >= {1'b0, good_cnt_reg});
    assign qneg    = good_sum_reg[SW-1] ? SW'(-quo_reg) : quo_reg;
    assign fetch_last = ((ptr_reg + CW'(1)) >= cnt_reg);

    always_comb
    begin
        v_next   = {v_reg[2:0], issue};
        d_next   = DW'($signed({1'b0, cnt_reg})) * DW'($signed(smp_rdata)) - DW'(sum_reg);
        d2_next  = (2*DW)'(dm) * (2*DW)'(dm);
        lhs_next = LW'(cnt_reg - CW'(1)) * LW'(d2_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        good_sum_next = good_sum_reg;
        good_cnt_next = good_cnt_reg;
        ptr_next      = ptr_reg;
        scan_next     = scan_reg;
        nq_next       = nq_reg;
        ss_next       = ss_reg;
        var_next      = var_reg;
        limit_next    = limit_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        mean_next     = mean_reg;
        res_vld_next  = res_vld_reg && result_stall;
        res_smp_next  = res_smp_reg;
        res_spk_next  = res_spk_reg;
        res_last_next = res_last_reg;

        if (v_reg[3] && !spike)
        begin
            good_sum_next = good_sum_reg + SW'($signed(x4_reg));
            good_cnt_next = good_cnt_reg + CW'(1);
        end

        unique case (state_reg)
            ST_LOAD, ST_READY:
            begin
                if (pop && (head.op == OP_LOAD))
                begin
                    cnt_next      = room ? b_cnt + CW'(1) : b_cnt;
                    sum_next      = room ? b_sum + SW'($signed(head_sample)) : b_sum;
                    sq_next       = room ? b_sq + QW'($unsigned(xx)) : b_sq;
                    ptr_next      = '0;
                    good_sum_next = '0;
                    good_cnt_next = '0;
                    state_next    = head.last ? ST_PRE_MUL : ST_LOAD;
                end
                else if (pop && ready_ph)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_PRE_MUL:
            begin
                nq_next    = VW'(cnt_reg) * VW'(sq_reg);
                ss_next    = $unsigned(ssq);
                state_next = ST_PRE_SUB;
            end
            ST_PRE_SUB:
            begin
                var_next   = nq_reg - ss_reg;
                state_next = ST_PRE_LIM;
            end
            ST_PRE_LIM:
            begin
                limit_next    = LW'(kmul) * LW'(var_reg);
                scan_next     = '0;
                good_sum_next = '0;
                good_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                else if (v_reg == 4'd0)
                begin
                    quo_next     = good_sum_reg[SW-1] ? SW'(-good_sum_reg) : SW'(good_sum_reg);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = ge ? CW'(trial - {1'b0, good_cnt_reg}) : CW'(trial);
                quo_next     = {quo_reg[SW-2:0], ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(SW - 1))
                begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX:
            begin
                mean_next  = (good_cnt_reg == '0) ? '0 : qneg[SAMPLE_BITS-1:0];
                ptr_next   = '0;
                state_next = ST_READY;
            end
            ST_FETCH:
            begin
                res_vld_next  = 1'b1;
                res_smp_next  = spk_rdata ? mean_reg : smp_rdata;
                res_spk_next  = spk_rdata;
                res_last_next = fetch_last;
                ptr_next      = ptr_reg + CW'(1);
                if (fetch_last)
                begin
                    cnt_next      = '0;
                    sum_next      = '0;
                    sq_next       = '0;
                    good_sum_next = '0;
                    good_cnt_next = '0;
                    ptr_next      = '0;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            good_sum_reg <= '0;
            good_cnt_reg <= '0;
            ptr_reg      <= '0;
            scan_reg     <= '0;
            div_cnt_reg  <= '0;
            v_reg        <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            good_sum_reg <= good_sum_next;
            good_cnt_reg <= good_cnt_next;
            ptr_reg      <= ptr_next;
            scan_reg     <= scan_next;
            div_cnt_reg  <= div_cnt_next;
            v_reg        <= v_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg       <= nq_next;
        ss_reg       <= ss_next;
        var_reg      <= var_next;
        limit_reg    <= limit_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        mean_reg     <= mean_next;
        idx1_reg     <= scan_reg[AW-1:0];
        idx2_reg     <= idx1_reg;
        idx3_reg     <= idx2_reg;
        idx4_reg     <= idx3_reg;
        x2_reg       <= smp_rdata;
        x3_reg       <= x2_reg;
        x4_reg       <= x3_reg;
        d_reg        <= d_next;
        d2_reg       <= d2_next;
        lhs_reg      <= lhs_next;
        res_smp_reg  <= res_smp_next;
        res_spk_reg  <= res_spk_next;
        res_last_reg <= res_last_next;
    end

    a_ready_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY) |-> (ptr_reg < cnt_reg))
        else $error("readout pointer past block end");

    a_fetch_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !res_vld_reg)
        else $error("result register busy at fetch");

    a_good_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (good_cnt_reg <= cnt_reg))
        else $error("good count exceeds block size");

    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |=> (v_reg[0] == 1'b0))
        else $error("scan pipeline issued outside scan");

endmodule

// ===== design/block_spike_replacer_core.sv =====
`timescale 1ns / 1ps
// Channel   Valid          Stall          Payload
// input     item_valid     item_stall     kind, sample, is_last
// result    result_valid   result_stall   cleaned_sample, was_spike, last_out
//
// A read goes through the store read, then the result register.
// The marked sample starts classification: setup (multiply, subtract, limit),
// a scan of one stored sample per cycle through the compare pipeline, then
// the mean divider; the queue fills and item_stall rises meanwhile.
// Reset clears all control state; sample and spike stores are not cleared.
module block_spike_replacer_core import bsr_pkg::*; #(
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   kind,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   is_last,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [SAMPLE_BITS-1:0] cleaned_sample,
    output logic                   was_spike,
    output logic                   last_out
);

    ctl_t                   head;
    logic [SAMPLE_BITS-1:0] head_sample;
    logic                   pop;

    bsr_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .kind        (kind),
        .sample      (sample),
        .is_last     (is_last),
        .head        (head),
        .head_sample (head_sample),
        .pop         (pop)
    );

    bsr_back #(.MAX_BLOCK(MAX_BLOCK), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_sample    (head_sample),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cleaned_sample (cleaned_sample),
        .was_spike      (was_spike),
        .last_out       (last_out)
    );

endmodule

// ===== sim/tb_block_spike_replacer_core.sv =====
`timescale 1ns / 1ps
module tb_block_spike_replacer_core;
    import bsr_pkg::*;

    localparam int NBLK  = MAX_BLOCK_DEF;
    localparam int SBITS = SAMPLE_BITS_DEF;

    typedef struct {
        op_t             op;
        logic [SBITS-1:0] smp;
        logic            lst;
    } item_t;

    typedef struct {
        logic [SBITS-1:0] val;
        logic            spk;
        logic            lst;
    } clean_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    logic             kind;
    logic [SBITS-1:0] sample;
    logic             is_last;
    logic             result_valid;
    logic             result_stall;
    logic [SBITS-1:0] cleaned_sample;
    logic             was_spike;
    logic             last_out;

    block_spike_replacer_core dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .kind(kind), .sample(sample), .is_last(is_last),
        .result_valid(result_valid), .result_stall(result_stall),
        .cleaned_sample(cleaned_sample), .was_spike(was_spike), .last_out(last_out)
    );

    item_t  pending_items[$];
    clean_t expected_clean[$];
    int     mismatches;
    int     n_accepted, n_results, n_spikes, n_blocks;
    int     hold_cycles;
    logic   hold_on;
    logic   in_acc;

    longint         blk_val[NBLK];
    bit             blk_spk[NBLK];
    int             blk_n;
    longint         blk_sum, blk_sq;
    longint         good_mean;
    int             rd_ptr;
    bit             reading;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic clear_block();
        blk_n = 0; blk_sum = 0; blk_sq = 0; good_mean = 0; rd_ptr = 0; reading = 0;
    endtask

    task automatic classify_block();
        logic signed [127:0] n, var_n, lim, d, lhs;
        longint gsum;
        int     gcnt;
        n     = blk_n;
        var_n = n * blk_sq - blk_sum * blk_sum;
        lim   = SIGMA_SQ * n * var_n;
        gsum  = 0;
        gcnt  = 0;
        for (int i = 0; i < blk_n; i++)
        begin
            d   = n * blk_val[i] - blk_sum;
            lhs = (n - 1) * d * d;
            blk_spk[i] = (blk_n >= 2) && (lhs > lim);
            if (!blk_spk[i])
            begin
                gsum += blk_val[i];
                gcnt++;
            end
        end
        good_mean = gcnt ? gsum / gcnt : 0;
        rd_ptr    = 0;
        reading   = 1;
    endtask

    task automatic predict_clean(item_t it);
        clean_t r;
        longint v;
        if (it.op == OP_LOAD)
        begin
            if (reading)
                clear_block();
            if (blk_n < NBLK)
            begin
                v = $signed(it.smp);
                blk_val[blk_n] = v;
                blk_sum += v;
                blk_sq  += v * v;
                blk_n++;
            end
            if (it.lst)
            begin
                if (blk_n == 0)
                    clear_block();
                else
                    classify_block();
            end
        end
        else if (reading && rd_ptr < blk_n)
        begin
            r.spk = blk_spk[rd_ptr];
            r.val = r.spk ? good_mean[SBITS-1:0] : blk_val[rd_ptr][SBITS-1:0];
            r.lst = (rd_ptr + 1 >= blk_n);
            expected_clean.push_back(r);
            rd_ptr++;
            if (r.lst)
                clear_block();
        end
    endtask

    always @(posedge clk)
    begin
        in_acc <= rst_n && item_valid && !item_stall;
    end

    // sender: bursts and gaps
    int burst_left, gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 0;
            kind       <= 0;
            sample     <= '0;
            is_last    <= 0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!item_valid || in_acc)
        begin
            if (gap_left > 0)
            begin
                gap_left   <= gap_left - 1;
                item_valid <= 0;
            end
            else if (pending_items.size() > 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                item_valid <= 1;
                kind       <= (it.op == OP_READ);
                sample     <= it.smp;
                is_last    <= it.lst;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                item_valid <= 0;
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_on = 0;
        @(posedge rst_n);
        repeat (50) @(negedge clk);
        hold_on = 1;
        repeat (800) @(negedge clk);
        hold_on = 0;
    end

    // receiver stall pattern
    int stall_mode;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 0;
            stall_mode   <= 0;
            hold_cycles  <= 0;
        end
        else if (hold_on || hold_cycles > 0)
        begin
            result_stall <= 1;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: result_stall <= 0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                default: result_stall <= ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 2999) == 0)
                hold_cycles <= $urandom_range(200, 600);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            item_t it;
            it.op  = kind ? OP_READ : OP_LOAD;
            it.smp = sample;
            it.lst = is_last;
            predict_clean(it);
            n_accepted++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            clean_t e;
            n_results++;
            if (was_spike)
                n_spikes++;
            if (expected_clean.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d spike=%0b last=%0b",
                             $signed(cleaned_sample), was_spike, last_out);
            end
            else
            begin
                e = expected_clean.pop_front();
                if (e.val !== cleaned_sample || e.spk !== was_spike || e.lst !== last_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 $signed(e.val), e.spk, e.lst,
                                 $signed(cleaned_sample), was_spike, last_out);
                end
            end
        end
    end

    function automatic logic [SBITS-1:0] rand_sample(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 65535) - 32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SBITS-1:0];
    endfunction

    task automatic add_item(op_t op, logic [SBITS-1:0] s, logic l);
        item_t it;
        it.op = op; it.smp = s; it.lst = l;
        pending_items.push_back(it);
    endtask

    task automatic add_block(int len, int base, int spread, int spikes, int reads);
        for (int i = 0; i < len; i++)
        begin
            logic [SBITS-1:0] s;
            s = rand_sample(base, spread);
            if (spikes > 0 && $urandom_range(0, len) < spikes)
                s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            add_item(OP_LOAD, s, i == len - 1);
        end
        n_blocks++;
        for (int i = 0; i < reads; i++)
            add_item(OP_READ, SBITS'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int total, len;
        rst_n        = 0;
        mismatches   = 0;
        n_accepted   = 0;
        n_results    = 0;
        n_spikes     = 0;
        n_blocks     = 0;
        clear_block();

        add_item(OP_READ, 16'h0000, 1'b1);
        add_item(OP_LOAD, 16'sh7fff, 1'b1);
        add_item(OP_READ, 16'hffff, 1'b0);
        add_item(OP_READ, 16'hffff, 1'b0);
        add_item(OP_LOAD, 16'sh8000, 1'b0);
        add_item(OP_LOAD, 16'sh7fff, 1'b1);
        add_item(OP_READ, '0, 1'b0);
        add_item(OP_READ, '0, 1'b0);
        for (int i = 0; i < 11; i++)
            add_item(OP_LOAD, (i == 10) ? 16'sh7fff : 16'sh8000, i == 10);
        for (int i = 0; i < 5; i++)
            add_item(OP_READ, '0, 1'b0);
        add_item(OP_LOAD, 16'h0005, 1'b1);
        add_item(OP_READ, '0, 1'b1);
        for (int i = 0; i < NBLK + 3; i++)
            add_item(OP_LOAD, (i == 7) ? 16'sh7fff : rand_sample(-100, 20), i == NBLK + 2);
        for (int i = 0; i < 20; i++)
            add_item(OP_READ, '0, 1'b0);
        add_item(OP_LOAD, 16'h1234, 1'b0);
        add_item(OP_LOAD, 16'h1235, 1'b0);
        add_item(OP_LOAD, 16'h0000, 1'b0);
        add_item(OP_LOAD, 16'h0000, 1'b1);
        add_item(OP_READ, '0, 1'b0);

        total = 0;
        while (total < 540)
        begin
            int r;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
            r   = $urandom_range(0, 5);
            add_block(len, $urandom_range(0, 65535) - 32768, $urandom_range(0, 3000),
                      $urandom_range(0, 2),
                      (r == 0) ? $urandom_range(0, len) : (r == 1 ? len + 3 : len));
            total += 2 * len;
            if ($urandom_range(0, 7) == 0)
                add_item(OP_READ, SBITS'($urandom), 1'($urandom));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (50) @(negedge clk);

        while (pending_items.size() > 0 || item_valid)
            @(posedge clk);
        while (expected_clean.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d items accepted in %0d blocks, %0d results checked, %0d spikes",
                 n_accepted, n_blocks, n_results, n_spikes);
        if (mismatches == 0 && expected_clean.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== block_spike_replacer_core.f =====
design/bsr_pkg.sv
design/bsr_ram.sv
design/bsr_front.sv
design/bsr_back.sv
design/block_spike_replacer_core.sv
sim/tb_block_spike_replacer_core.sv
